// ----- design/kmfe_pkg.sv -----
// ----------------------------------------------------------------------------
// kmfe_pkg
// Types and constants shared by the motor frame encoder modules.
// ----------------------------------------------------------------------------
package kmfe_pkg;

	localparam int unsigned FRAME_LEN = 18;
	localparam int unsigned IDX_W     = 5;

	localparam logic [7:0] HEAD0 = 8'd128;
	localparam logic [7:0] HEAD1 = 8'd16;

	localparam logic [7:0] KEY_W     = 8'h77;
	localparam logic [7:0] KEY_A     = 8'h61;
	localparam logic [7:0] KEY_S     = 8'h73;
	localparam logic [7:0] KEY_D     = 8'h64;
	localparam logic [7:0] KEY_J     = 8'h6A;
	localparam logic [7:0] KEY_L     = 8'h6C;
	localparam logic [7:0] KEY_K     = 8'h6B;
	localparam logic [7:0] KEY_I     = 8'h69;
	localparam logic [7:0] KEY_SPACE = 8'h20;

	localparam logic [1:0] REG_MIN_POWER  = 2'd0;
	localparam logic [1:0] REG_MAX_POWER  = 2'd1;
	localparam logic [1:0] REG_POWER_STEP = 2'd2;

	localparam logic [7:0] RST_MIN_POWER  = 8'd100;
	localparam logic [7:0] RST_MAX_POWER  = 8'd255;
	localparam logic [7:0] RST_POWER_STEP = 8'd5;
	localparam logic [7:0] RST_POWER      = 8'd200;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_ID   = 2'd1;
	localparam logic [1:0] SEL_DIR  = 2'd2;
	localparam logic [1:0] SEL_POW  = 2'd3;

	typedef struct packed {
		logic [3:0] dirs;
		logic [7:0] power;
	} frame_t;

	typedef struct packed {
		logic   push;
		frame_t data;
	} q_wr_t;

	function automatic logic [7:0] frame_byte_of(input logic [IDX_W-1:0] idx,
		input frame_t f);
		logic [IDX_W-1:0] j;
		logic [1:0]       m;
		logic [7:0]       b;
		j = idx - IDX_W'(2);
		m = j[3:2];
		if (idx == '0) begin
			b = HEAD0;
		end else if (idx == IDX_W'(1)) begin
			b = HEAD1;
		end else begin
			case (j[1:0])
				SEL_ZERO: b = 8'd0;
				SEL_ID:   b = {6'd0, m};
				SEL_DIR:  b = {7'd0, f.dirs[m]};
				SEL_POW:  b = f.power;
				default:  b = 8'd0;
			endcase
		end
		return b;
	endfunction

endpackage

// ----- design/kmfe_front.sv -----
// ----------------------------------------------------------------------------
// kmfe_front
// Decodes keys, holds power level, directions and limit registers, and
// queues one frame descriptor per key.
// ----------------------------------------------------------------------------
module kmfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          key_code,
	input  logic                q_full,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output kmfe_pkg::q_wr_t     q_wr
);
	import kmfe_pkg::*;

	logic [7:0] min_power_q;
	logic [7:0] max_power_q;
	logic [7:0] power_step_q;
	logic [7:0] power_q;
	logic [3:0] dirs_q;

	logic [7:0] power_d;
	logic [3:0] dirs_d;
	logic [7:0] below;
	logic [7:0] above;
	logic       accept;

	assign accept = push && !q_full;
	assign below  = power_q - min_power_q;
	assign above  = max_power_q - power_q;

	always_comb begin
		power_d = power_q;
		dirs_d  = dirs_q;
		case (key_code)
			KEY_W: dirs_d = 4'hF;
			KEY_A: dirs_d = 4'h5;
			KEY_S: dirs_d = 4'h0;
			KEY_D: dirs_d = 4'hA;
			KEY_J: dirs_d = 4'hC;
			KEY_L: dirs_d = 4'h3;
			KEY_K: begin
				if (power_q > min_power_q) begin
					power_d = (below < power_step_q) ? min_power_q : power_q - power_step_q;
				end
			end
			KEY_I: begin
				if (power_q < max_power_q) begin
					power_d = (above < power_step_q) ? max_power_q : power_q + power_step_q;
				end
			end
			default: ;
		endcase
	end

	assign q_wr.push       = accept;
	assign q_wr.data.dirs  = dirs_d;
	assign q_wr.data.power = (key_code == KEY_SPACE) ? 8'd0 : power_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= RST_POWER;
			dirs_q  <= 4'h0;
		end else if (accept) begin
			power_q <= power_d;
			dirs_q  <= dirs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_power_q  <= RST_MIN_POWER;
			max_power_q  <= RST_MAX_POWER;
			power_step_q <= RST_POWER_STEP;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MIN_POWER:  min_power_q  <= cfg_data;
				REG_MAX_POWER:  max_power_q  <= cfg_data;
				REG_POWER_STEP: power_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/kmfe_fifo.sv -----
// ----------------------------------------------------------------------------
// kmfe_fifo
// Two-entry queue of frame descriptors between front and back.
// ----------------------------------------------------------------------------
module kmfe_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  kmfe_pkg::q_wr_t  q_wr,
	input  logic             q_pop,
	output logic             q_full,
	output logic             q_empty,
	output kmfe_pkg::frame_t q_head
);
	import kmfe_pkg::*;

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign q_head  = mem_q[rd_ptr_q];
	assign do_push = q_wr.push && !q_full;
	assign do_pop  = q_pop && !q_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/kmfe_back.sv -----
// ----------------------------------------------------------------------------
// kmfe_back
// Serializes the head frame descriptor into 18 bytes, one per cycle while
// pop takes each byte, through an output register.
// ----------------------------------------------------------------------------
module kmfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  kmfe_pkg::frame_t q_head,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       frame_byte,
	output logic             last_of_frame
);
	import kmfe_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             load;

	assign load  = !q_empty && (!valid_q || pop);
	assign q_pop = load && (idx_q == LAST_IDX);

	assign empty         = !valid_q;
	assign frame_byte    = byte_q;
	assign last_of_frame = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= frame_byte_of(idx_q, q_head);
			last_q <= (idx_q == LAST_IDX);
		end
	end

endmodule

// ----- design/keystroke_motor_frame_encoder.sv -----
// A taken key is queued, then its first frame byte loads the output register.
// Throughput: one frame byte per cycle while pop takes every byte, set by the
// single byte serializer in the back end.
// A two-entry descriptor queue holds the frame in progress and one further key.
// Reset: power 200, all motors reverse, limits 100/255, step 5, queue empty.
// ----------------------------------------------------------------------------
// keystroke_motor_frame_encoder
// Turns command keys into 18-byte motor command frames.
// ----------------------------------------------------------------------------
module keystroke_motor_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] key_code,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] frame_byte,
	output logic       last_of_frame,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import kmfe_pkg::*;

	q_wr_t  q_wr;
	frame_t q_head;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;

	assign full = q_full;

	kmfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.key_code  (key_code),
		.q_full    (q_full),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_wr      (q_wr)
	);

	kmfe_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_wr    (q_wr),
		.q_pop   (q_pop),
		.q_full  (q_full),
		.q_empty (q_empty),
		.q_head  (q_head)
	);

	kmfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.frame_byte    (frame_byte),
		.last_of_frame (last_of_frame)
	);

endmodule
